// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/flbc_pkg.sv -----
`default_nettype none
package flbc_pkg;

  localparam int SECTOR_BYTES = 4096;
  localparam int SECTOR_SHIFT = 12;

  localparam logic [31:0] MAGIC_WORD   = 32'hDEADBEEF;
  localparam logic [31:0] FREE_WORD    = 32'hFFFFFFFF;
  localparam logic [31:0] DELETED_WORD = 32'h00000000;

  typedef enum logic [1:0] {
    MODE_FIND = 2'd0,
    MODE_SAVE = 2'd1,
    MODE_RESP = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CMD_READ_COOKIE = 3'd0,
    CMD_WRITE_ZERO  = 3'd1,
    CMD_ERASE       = 3'd2,
    CMD_WRITE_OBJ   = 3'd3,
    CMD_READ_OBJ    = 3'd4,
    CMD_NOT_FOUND   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_FIND = 3'b010,
    PH_SAVE = 3'b100
  } phase_t;

  typedef struct packed {
    cmd_t        command;
    logic [23:0] address;
    logic [11:0] sector_number;
    logic        last;
  } res_t;

  // Outcome of one input beat: next cursor state plus up to three results.
  typedef struct packed {
    phase_t       phase;
    logic [7:0]   sector_cursor;
    logic [11:0]  block_cursor;
    logic [1:0]   cnt;
    res_t [2:0]   res;
  } step_t;

endpackage
`default_nettype wire

// ----- rtl/flbc_in_if.sv -----
`default_nettype none
interface flbc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] cookie;

  modport source (output valid, output mode, output cookie, input ready);
  modport sink   (input valid, input mode, input cookie, output ready);
endinterface
`default_nettype wire

// ----- rtl/flbc_out_if.sv -----
`default_nettype none
interface flbc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [23:0] address;
  logic [11:0] sector_number;
  logic        last;

  modport source (output valid, output command, output address, output sector_number,
                  output last, input ready);
  modport sink   (input valid, input command, input address, input sector_number,
                  input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/flbc_step.sv -----
`default_nettype none
module flbc_step #(
  parameter int SECTORS     = 4,
  parameter int BLOCK_BYTES = 256
) (
  input  wire logic [1:0]      mode,
  input  wire logic [31:0]     cookie,
  input  wire flbc_pkg::phase_t phase,
  input  wire logic [7:0]      sector_cursor,
  input  wire logic [11:0]     block_cursor,
  input  wire logic [11:0]     start_sector,
  output flbc_pkg::step_t      st
);
  import flbc_pkg::*;

  localparam logic [7:0]  SECTORS_W = 8'(SECTORS);
  localparam logic [11:0] BPS_W     = 12'(SECTOR_BYTES / BLOCK_BYTES);
  localparam logic [23:0] BB_W      = 24'(BLOCK_BYTES);

  function automatic res_t mk(input cmd_t cmd, input logic [7:0] sc, input logic [11:0] bc,
                              input logic lst);
    logic [11:0] sec;
    res_t        r;
    sec             = 12'(start_sector + {4'b0, sc});
    r.command       = cmd;
    r.sector_number = sec;
    r.address       = (24'(sec) << SECTOR_SHIFT) + 24'(bc) * BB_W;
    r.last          = lst;
    return r;
  endfunction

  always_comb begin
    logic [7:0]  sc1;
    logic [7:0]  sc2;
    logic [11:0] bc1;
    logic [11:0] bc2;
    logic        cont;
    logic        cont_save;
    logic [1:0]  n;
    st       = '0;
    st.phase = phase;
    st.sector_cursor = sector_cursor;
    st.block_cursor  = block_cursor;
    sc1 = sector_cursor;
    bc1 = block_cursor;
    sc2 = sector_cursor;
    bc2 = block_cursor;
    cont      = 1'b0;
    cont_save = 1'b0;
    n         = 2'd0;

    unique case (mode)
      MODE_FIND: begin
        st.phase = PH_FIND;
        cont     = 1'b1;
      end
      MODE_SAVE: begin
        st.phase  = PH_SAVE;
        cont      = 1'b1;
        cont_save = 1'b1;
      end
      MODE_RESP: begin
        unique case (phase)
          PH_FIND: begin
            if (cookie == MAGIC_WORD) begin
              st.phase = PH_IDLE;
              st.res[0] = mk(CMD_READ_OBJ, sector_cursor, block_cursor, 1'b1);
              n = 2'd1;
            end else begin
              bc1  = 12'(block_cursor + 12'd1);
              cont = 1'b1;
            end
          end
          PH_SAVE: begin
            if (cookie == FREE_WORD) begin
              st.phase = PH_IDLE;
              st.res[0] = mk(CMD_WRITE_OBJ, sector_cursor, block_cursor, 1'b1);
              n = 2'd1;
            end else begin
              if (cookie != DELETED_WORD) begin
                st.res[0] = mk(CMD_WRITE_ZERO, sector_cursor, block_cursor, 1'b0);
                n = 2'd1;
              end
              bc1       = 12'(block_cursor + 12'd1);
              cont      = 1'b1;
              cont_save = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    if (cont) begin
      sc2 = sc1;
      bc2 = bc1;
      // cursor ran off the end of its sector: step to the next one
      if (sc1 < SECTORS_W && bc1 >= BPS_W) begin
        bc2 = '0;
        sc2 = 8'(sc1 + 8'd1);
        if (cont_save) begin
          st.res[n] = mk(CMD_ERASE, sc1, 12'd0, 1'b0);
          n = 2'(n + 2'd1);
        end
      end
      if (sc2 >= SECTORS_W) begin
        sc2      = '0;
        bc2      = '0;
        st.phase = PH_IDLE;
        if (cont_save) begin
          st.res[n] = mk(CMD_WRITE_OBJ, 8'd0, 12'd0, 1'b1);
        end else begin
          st.res[n] = '{command: CMD_NOT_FOUND, address: 24'd0, sector_number: 12'd0,
                        last: 1'b1};
        end
      end else begin
        st.res[n] = mk(CMD_READ_COOKIE, sc2, bc2, 1'b0);
      end
      n = 2'(n + 2'd1);
    end

    if (cont) begin
      st.sector_cursor = sc2;
      st.block_cursor  = bc2;
    end else begin
      st.sector_cursor = sc1;
      st.block_cursor  = bc1;
    end
    st.cnt = n;
  end

endmodule
`default_nettype wire

// ----- rtl/flash_log_block_cursor_unit.sv -----
// A beat is registered at the input stage, then its results in the result buffer.
// Throughput: one input beat per cycle while each beat yields at most one result and
// the output is ready; a beat with more results (up to three) stalls the next beat.
// The result buffer drains one beat per ready cycle and gates the input stage.
// Reset (rst_n low, synchronous) clears cursors, phase, start sector and all valids.
`default_nettype none
`include "assert_macros.svh"
module flash_log_block_cursor_unit #(
  parameter int SECTORS     = 4,
  parameter int BLOCK_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_wdata,
  flbc_in_if.sink          in_bus,
  flbc_out_if.source       out_bus
);
  import flbc_pkg::*;

  localparam logic [7:0]  SECTORS_W = 8'(SECTORS);
  localparam logic [11:0] BPS_W     = 12'(SECTOR_BYTES / BLOCK_BYTES);

  logic [11:0] start_r;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  sc_r, sc_nxt;
  logic [11:0] bc_r, bc_nxt;

  logic        in_v_r, in_v_nxt;
  logic [1:0]  mode_r;
  logic [31:0] cookie_r;

  res_t [2:0]  res_r, res_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  step_t       st;
  logic        pop, go, accept;

  assign pop    = out_bus.valid && out_bus.ready;
  assign go     = in_v_r && ((cnt_r == 2'd0) || (cnt_r == 2'd1 && out_bus.ready));
  assign in_bus.ready = !in_v_r || go;
  assign accept = in_bus.valid && in_bus.ready;

  assign out_bus.valid         = (cnt_r != 2'd0);
  assign out_bus.command       = res_r[0].command;
  assign out_bus.address       = res_r[0].address;
  assign out_bus.sector_number = res_r[0].sector_number;
  assign out_bus.last          = res_r[0].last;

  flbc_step #(.SECTORS(SECTORS), .BLOCK_BYTES(BLOCK_BYTES)) u_step (
    .mode          (mode_r),
    .cookie        (cookie_r),
    .phase         (phase_r),
    .sector_cursor (sc_r),
    .block_cursor  (bc_r),
    .start_sector  (start_r),
    .st            (st)
  );

  always_comb begin
    in_v_nxt  = accept ? 1'b1 : (go ? 1'b0 : in_v_r);
    phase_nxt = go ? st.phase : phase_r;
    sc_nxt    = go ? st.sector_cursor : sc_r;
    bc_nxt    = go ? st.block_cursor : bc_r;
    res_nxt   = res_r;
    cnt_nxt   = cnt_r;
    if (go) begin
      // buffer is empty or its last beat leaves this cycle
      res_nxt = st.res;
      cnt_nxt = st.cnt;
    end else if (pop) begin
      res_nxt[0] = res_r[1];
      res_nxt[1] = res_r[2];
      cnt_nxt    = 2'(cnt_r - 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      phase_r <= PH_IDLE;
      sc_r    <= '0;
      bc_r    <= '0;
      in_v_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        start_r <= cfg_wdata;
      end
      phase_r <= phase_nxt;
      sc_r    <= sc_nxt;
      bc_r    <= bc_nxt;
      in_v_r  <= in_v_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= in_bus.mode;
      cookie_r <= in_bus.cookie;
    end
    res_r <= res_nxt;
  end

  `ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> (cnt_r == 2'd0 && !in_v_r), "buffer not empty after reset")
  `ASSERT_RST(a_sc_range, clk, rst_n, sc_r < SECTORS_W, "sector cursor out of region")
  `ASSERT_RST(a_bc_range, clk, rst_n, bc_r < BPS_W, "block cursor out of sector")
  `ASSERT_RST(a_last_tail, clk, rst_n, (go && st.cnt > 2'd1) |-> !st.res[0].last, "last beat not at end of batch")
  `ASSERT_RST(a_idle_last, clk, rst_n, (go && st.cnt != 2'd0 && st.phase != PH_IDLE) |-> !st.res[st.cnt - 2'd1].last, "last beat while still busy")

endmodule
`default_nettype wire
